// ===== design/r2k_pkg.sv =====
// Package: constants and table lookup for the romaji-to-kana block.
package r2k_pkg;

  localparam logic [15:0] KANA_N      = 16'h3093;
  localparam logic [15:0] KANA_SOKUON = 16'h3063;
  localparam logic [15:0] CH_APOS     = 16'h0027;
  localparam logic [15:0] CH_A        = 16'h0061;
  localparam logic [15:0] CH_Z        = 16'h007A;
  localparam logic [15:0] CH_N        = 16'h006E;
  localparam logic [15:0] CH_Y        = 16'h0079;

  // Rule that overrides the table lookup.
  localparam logic [1:0] RULE_NONE   = 2'd0;
  localparam logic [1:0] RULE_NN     = 2'd1;
  localparam logic [1:0] RULE_NC     = 2'd2;
  localparam logic [1:0] RULE_SOKUON = 2'd3;

  typedef logic [7:0] letter_t;

  // Match result of one lookup.
  typedef struct packed {
    logic [2:0]  len;
    logic [15:0] k0;
    logic [15:0] k1;
  } hit_t;

  function automatic logic is_cons(input logic [15:0] c);
    logic v;
    begin
      v = (c == 16'h61) || (c == 16'h69) || (c == 16'h75) || (c == 16'h65) || (c == 16'h6F);
      return (c >= CH_A) && (c <= CH_Z) && !v;
    end
  endfunction

  // Single-letter entries (vowels).
  function automatic hit_t look1(input letter_t a);
    hit_t h;
    begin
      h = '0;
      case (a)
        "a": h = '{3'd1, 16'h3042, 16'h0};
        "i": h = '{3'd1, 16'h3044, 16'h0};
        "u": h = '{3'd1, 16'h3046, 16'h0};
        "e": h = '{3'd1, 16'h3048, 16'h0};
        "o": h = '{3'd1, 16'h304A, 16'h0};
        default: h = '0;
      endcase
      return h;
    end
  endfunction

  function automatic hit_t look2(input letter_t a, input letter_t b);
    hit_t h;
    begin
      h = '0;
      h.len = 3'd2;
      case ({a, b})
        "ka": h.k0 = 16'h304B; "ki": h.k0 = 16'h304D; "ku": h.k0 = 16'h304F;
        "ke": h.k0 = 16'h3051; "ko": h.k0 = 16'h3053;
        "ga": h.k0 = 16'h304C; "gi": h.k0 = 16'h304E; "gu": h.k0 = 16'h3050;
        "ge": h.k0 = 16'h3052; "go": h.k0 = 16'h3054;
        "sa": h.k0 = 16'h3055; "si": h.k0 = 16'h3057; "su": h.k0 = 16'h3059;
        "se": h.k0 = 16'h305B; "so": h.k0 = 16'h305D;
        "za": h.k0 = 16'h3056; "zi": h.k0 = 16'h3058; "ji": h.k0 = 16'h3058;
        "zu": h.k0 = 16'h305A; "ze": h.k0 = 16'h305C; "zo": h.k0 = 16'h305E;
        "ta": h.k0 = 16'h305F; "ti": h.k0 = 16'h3061; "tu": h.k0 = 16'h3064;
        "te": h.k0 = 16'h3066; "to": h.k0 = 16'h3068;
        "da": h.k0 = 16'h3060; "di": h.k0 = 16'h3062; "du": h.k0 = 16'h3065;
        "de": h.k0 = 16'h3067; "do": h.k0 = 16'h3069;
        "na": h.k0 = 16'h306A; "ni": h.k0 = 16'h306B; "nu": h.k0 = 16'h306C;
        "ne": h.k0 = 16'h306D; "no": h.k0 = 16'h306E;
        "ha": h.k0 = 16'h306F; "hi": h.k0 = 16'h3072; "hu": h.k0 = 16'h3075;
        "fu": h.k0 = 16'h3075; "he": h.k0 = 16'h3078; "ho": h.k0 = 16'h307B;
        "ba": h.k0 = 16'h3070; "bi": h.k0 = 16'h3073; "bu": h.k0 = 16'h3076;
        "be": h.k0 = 16'h3079; "bo": h.k0 = 16'h307C;
        "pa": h.k0 = 16'h3071; "pi": h.k0 = 16'h3074; "pu": h.k0 = 16'h3077;
        "pe": h.k0 = 16'h307A; "po": h.k0 = 16'h307D;
        "ma": h.k0 = 16'h307E; "mi": h.k0 = 16'h307F; "mu": h.k0 = 16'h3080;
        "me": h.k0 = 16'h3081; "mo": h.k0 = 16'h3082;
        "ya": h.k0 = 16'h3084; "yu": h.k0 = 16'h3086; "yo": h.k0 = 16'h3088;
        "ra": h.k0 = 16'h3089; "ri": h.k0 = 16'h308A; "ru": h.k0 = 16'h308B;
        "re": h.k0 = 16'h308C; "ro": h.k0 = 16'h308D;
        "wa": h.k0 = 16'h308F; "wo": h.k0 = 16'h3092;
        "ja": begin h.k0 = 16'h3058; h.k1 = 16'h3083; end
        "ju": begin h.k0 = 16'h3058; h.k1 = 16'h3085; end
        "jo": begin h.k0 = 16'h3058; h.k1 = 16'h3087; end
        "fa": begin h.k0 = 16'h3075; h.k1 = 16'h3041; end
        "fi": begin h.k0 = 16'h3075; h.k1 = 16'h3043; end
        "fe": begin h.k0 = 16'h3075; h.k1 = 16'h3047; end
        "fo": begin h.k0 = 16'h3075; h.k1 = 16'h3049; end
        "va": begin h.k0 = 16'h3094; h.k1 = 16'h3041; end
        "vi": begin h.k0 = 16'h3094; h.k1 = 16'h3043; end
        "vu": h.k0 = 16'h3094;
        "ve": begin h.k0 = 16'h3094; h.k1 = 16'h3047; end
        "vo": begin h.k0 = 16'h3094; h.k1 = 16'h3049; end
        "je": begin h.k0 = 16'h3058; h.k1 = 16'h3047; end
        "wi": begin h.k0 = 16'h3046; h.k1 = 16'h3043; end
        "we": begin h.k0 = 16'h3046; h.k1 = 16'h3047; end
        "ye": begin h.k0 = 16'h3044; h.k1 = 16'h3047; end
        "la": h.k0 = 16'h3041; "li": h.k0 = 16'h3043; "lu": h.k0 = 16'h3045;
        "le": h.k0 = 16'h3047; "lo": h.k0 = 16'h3049;
        "xa": h.k0 = 16'h3041; "xi": h.k0 = 16'h3043; "xu": h.k0 = 16'h3045;
        "xe": h.k0 = 16'h3047; "xo": h.k0 = 16'h3049;
        default: h = '0;
      endcase
      return h;
    end
  endfunction

  function automatic hit_t look3(input letter_t a, input letter_t b, input letter_t c);
    hit_t h;
    logic [15:0] y0;
    begin
      h = '0;
      h.len = 3'd3;
      y0 = 16'h0;
      // y-row contractions: consonant prefix then ya/yu/yo
      case ({a, b})
        "ky": y0 = 16'h304D; "gy": y0 = 16'h304E; "sh": y0 = 16'h3057;
        "sy": y0 = 16'h3057; "jy": y0 = 16'h3058; "zy": y0 = 16'h3058;
        "ch": y0 = 16'h3061; "ty": y0 = 16'h3061; "cy": y0 = 16'h3061;
        "dy": y0 = 16'h3062; "ny": y0 = 16'h306B; "hy": y0 = 16'h3072;
        "by": y0 = 16'h3073; "py": y0 = 16'h3074; "my": y0 = 16'h307F;
        "ry": y0 = 16'h308A;
        default: y0 = 16'h0;
      endcase
      case ({a, b, c})
        "shi": h.k0 = 16'h3057;
        "chi": h.k0 = 16'h3061;
        "tsu": h.k0 = 16'h3064;
        "she": begin h.k0 = 16'h3057; h.k1 = 16'h3047; end
        "che": begin h.k0 = 16'h3061; h.k1 = 16'h3047; end
        "tsa": begin h.k0 = 16'h3064; h.k1 = 16'h3041; end
        "tsi": begin h.k0 = 16'h3064; h.k1 = 16'h3043; end
        "tse": begin h.k0 = 16'h3064; h.k1 = 16'h3047; end
        "tso": begin h.k0 = 16'h3064; h.k1 = 16'h3049; end
        "lya", "xya": h.k0 = 16'h3083;
        "lyu", "xyu": h.k0 = 16'h3085;
        "lyo", "xyo": h.k0 = 16'h3087;
        "ltu", "xtu": h.k0 = 16'h3063;
        "lwa", "xwa": h.k0 = 16'h308E;
        default: begin
          h.k0 = y0;
          case (c)
            "a": h.k1 = 16'h3083;
            "u": h.k1 = 16'h3085;
            "o": h.k1 = 16'h3087;
            default: h.k0 = 16'h0;
          endcase
          if (h.k0 == 16'h0) h = '0;
        end
      endcase
      return h;
    end
  endfunction

endpackage

// ===== design/r2k_match.sv =====
// Match stage: table lookups for each prefix length plus rule flags, registered.
module r2k_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  logic [15:0]         c0,
  input  logic [15:0]         c1,
  input  logic [15:0]         c2,
  input  logic [15:0]         c3,
  input  logic [2:0]          avail,
  output logic                vld_out,
  output r2k_pkg::hit_t       h1_r,
  output r2k_pkg::hit_t       h2_r,
  output r2k_pkg::hit_t       h3_r,
  output logic                h4_r,
  output logic [1:0]          rule_r
);
  import r2k_pkg::*;

  logic hi1, hi2, hi3, hi4;
  logic nn, nc, sk;
  logic [1:0] rule_nxt;
  logic vld_r;

  // upper bytes must be zero for any table letter
  assign hi1 = (c0[15:8] == 8'h0);
  assign hi2 = hi1 && (c1[15:8] == 8'h0);
  assign hi3 = hi2 && (c2[15:8] == 8'h0);
  assign hi4 = hi3 && (c3[15:8] == 8'h0);

  assign nn = (c0 == CH_N) && (avail >= 3'd2) && ((c1 == CH_N) || (c1 == CH_APOS));
  assign nc = (c0 == CH_N) && (avail >= 3'd2) && is_cons(c1) && (c1 != CH_Y);
  assign sk = (avail >= 3'd2) && is_cons(c0) && (c0 != CH_N) && (c1 == c0);

  always_comb begin
    if (avail == 3'd0) rule_nxt = RULE_NONE;
    else if (nn)       rule_nxt = RULE_NN;
    else if (nc)       rule_nxt = RULE_NC;
    else if (sk)       rule_nxt = RULE_SOKUON;
    else               rule_nxt = RULE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    rule_r <= rule_nxt;
    h1_r <= (hi1 && avail >= 3'd1) ? look1(c0[7:0]) : '0;
    h2_r <= (hi2 && avail >= 3'd2) ? look2(c0[7:0], c1[7:0]) : '0;
    h3_r <= (hi3 && avail >= 3'd3) ? look3(c0[7:0], c1[7:0], c2[7:0]) : '0;
    h4_r <= hi4 && (avail >= 3'd4) && ({c0[7:0], c1[7:0], c2[7:0], c3[7:0]} == "ltsu");
  end

  assign vld_out = vld_r;
endmodule

// ===== design/romaji_to_kana_longest_match.sv =====
// Top level: romaji-to-hiragana longest-match converter, three-stage pipeline.
// Usage: drive a window of up to four UTF-16 units and avail_count (values
// above the window size or above four saturate) with start high; busy is
// never asserted, so a request is taken every cycle. Each request yields
// exactly one result, flagged by out_valid for one cycle, in order. The
// receiver cannot stall and need not: results never back up. Stage one
// registers the window, stage two looks up all prefix lengths in the constant
// table and evaluates the n/sokuon rules, stage three picks the winner.
module romaji_to_kana_longest_match #(
  parameter int WINDOW_CHARS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_char0,
  input  logic [15:0] in_char1,
  input  logic [15:0] in_char2,
  input  logic [15:0] in_char3,
  input  logic [2:0]  in_avail_count,
  output logic        out_valid,
  output logic [2:0]  out_consumed,
  output logic [1:0]  out_kana_count,
  output logic [15:0] out_kana_first,
  output logic [15:0] out_kana_second
);
  import r2k_pkg::*;

  // Only the first four units are ever looked at, so saturation at four is
  // the same for any window size from four up.
  localparam logic [2:0] SAT = (WINDOW_CHARS > 4) ? 3'd4 : 3'(WINDOW_CHARS);

  logic        v1_r;
  logic [15:0] c0_r, c1_r, c2_r, c3_r;
  logic [2:0]  av_r, av_nxt;

  logic        v2;
  hit_t        h1, h2, h3;
  logic        h4;
  logic [1:0]  rule;

  hit_t        pick;
  logic        ov_r;
  logic [2:0]  cons_r, cons_nxt;
  logic [1:0]  kc_r, kc_nxt;
  logic [15:0] ka_r, ka_nxt, kb_r, kb_nxt;

  assign busy   = 1'b0;
  assign av_nxt = (in_avail_count > SAT) ? SAT : in_avail_count;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    c0_r <= in_char0;
    c1_r <= in_char1;
    c2_r <= in_char2;
    c3_r <= in_char3;
    av_r <= av_nxt;
  end

  // stage 2: lookups
  r2k_match u_match (
    .clk(clk), .rst_n(rst_n), .vld_in(v1_r),
    .c0(c0_r), .c1(c1_r), .c2(c2_r), .c3(c3_r), .avail(av_r),
    .vld_out(v2), .h1_r(h1), .h2_r(h2), .h3_r(h3), .h4_r(h4), .rule_r(rule)
  );

  // stage 3: priority select; longest table hit wins, n/sokuon rules override it
  always_comb begin
    if (h4)                   pick = '{3'd4, KANA_SOKUON, 16'h0};
    else if (h3.len != 3'd0)  pick = h3;
    else if (h2.len != 3'd0)  pick = h2;
    else                      pick = h1;
    cons_nxt = pick.len;
    ka_nxt   = pick.k0;
    kb_nxt   = pick.k1;
    kc_nxt   = (pick.len == 3'd0) ? 2'd0 : ((pick.k1 != 16'h0) ? 2'd2 : 2'd1);
    case (rule)
      RULE_NN: begin
        cons_nxt = 3'd2; kc_nxt = 2'd1; ka_nxt = KANA_N; kb_nxt = 16'h0;
      end
      RULE_NC: begin
        cons_nxt = 3'd1; kc_nxt = 2'd1; ka_nxt = KANA_N; kb_nxt = 16'h0;
      end
      RULE_SOKUON: begin
        cons_nxt = 3'd1; kc_nxt = 2'd1; ka_nxt = KANA_SOKUON; kb_nxt = 16'h0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v2;
    end
    cons_r <= cons_nxt;
    kc_r   <= kc_nxt;
    ka_r   <= ka_nxt;
    kb_r   <= kb_nxt;
  end

  assign out_valid       = ov_r;
  assign out_consumed    = cons_r;
  assign out_kana_count  = kc_r;
  assign out_kana_first  = ka_r;
  assign out_kana_second = kb_r;
endmodule

// ===== test/romaji_to_kana_longest_match_test.sv =====
// Testbench for the romaji-to-kana longest-match converter: directed and random windows.
`timescale 1ns / 1ps

module romaji_to_kana_longest_match_test;
  import r2k_pkg::*;

  // Expected conversion of one window
  typedef struct packed {
    logic [2:0]  consumed;
    logic [1:0]  kana_count;
    logic [15:0] kana_first;
    logic [15:0] kana_second;
  } kana_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 29;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_char0, in_char1, in_char2, in_char3;
  logic [2:0]  in_avail_count;
  logic        out_valid;
  logic [2:0]  out_consumed;
  logic [1:0]  out_kana_count;
  logic [15:0] out_kana_first;
  logic [15:0] out_kana_second;

  kana_t pending_kana[$];   // predictions for requests not yet answered
  int    mismatches;
  int    cycles;
  logic  busy_s;            // busy as it stands just before the next edge
  logic  idle_on;           // random sender gaps enabled

  romaji_to_kana_longest_match dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_char0(in_char0), .in_char1(in_char1), .in_char2(in_char2),
    .in_char3(in_char3), .in_avail_count(in_avail_count),
    .out_valid(out_valid), .out_consumed(out_consumed),
    .out_kana_count(out_kana_count), .out_kana_first(out_kana_first),
    .out_kana_second(out_kana_second)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Hard stop in case the block hangs or drops a result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Conversion table. Returns {first, second} kana, zero when no entry.
  // s holds the spelling right aligned, one ASCII byte per letter.
  // ------------------------------------------------------------------
  function automatic logic [15:0] y_row_head(input logic [15:0] p);
    case (p)
      "ky": return 16'h304D; "gy": return 16'h304E; "sh": return 16'h3057;
      "sy": return 16'h3057; "jy": return 16'h3058; "zy": return 16'h3058;
      "ch": return 16'h3061; "ty": return 16'h3061; "cy": return 16'h3061;
      "dy": return 16'h3062; "ny": return 16'h306B; "hy": return 16'h3072;
      "by": return 16'h3073; "py": return 16'h3074; "my": return 16'h307F;
      "ry": return 16'h308A;
      default: return 16'h0;
    endcase
  endfunction

  function automatic logic [31:0] spelling_kana(input int len, input logic [31:0] s);
    logic [15:0] head;
    case (len)
      1: case (s[7:0])
        "a": return 32'h30420000; "i": return 32'h30440000; "u": return 32'h30460000;
        "e": return 32'h30480000; "o": return 32'h304A0000;
        default: return 32'h0;
      endcase
      2: case (s[15:0])
        "ka": return 32'h304B0000; "ki": return 32'h304D0000; "ku": return 32'h304F0000;
        "ke": return 32'h30510000; "ko": return 32'h30530000;
        "ga": return 32'h304C0000; "gi": return 32'h304E0000; "gu": return 32'h30500000;
        "ge": return 32'h30520000; "go": return 32'h30540000;
        "sa": return 32'h30550000; "si": return 32'h30570000; "su": return 32'h30590000;
        "se": return 32'h305B0000; "so": return 32'h305D0000;
        "za": return 32'h30560000; "zi": return 32'h30580000; "ji": return 32'h30580000;
        "zu": return 32'h305A0000; "ze": return 32'h305C0000; "zo": return 32'h305E0000;
        "ta": return 32'h305F0000; "ti": return 32'h30610000; "tu": return 32'h30640000;
        "te": return 32'h30660000; "to": return 32'h30680000;
        "da": return 32'h30600000; "di": return 32'h30620000; "du": return 32'h30650000;
        "de": return 32'h30670000; "do": return 32'h30690000;
        "na": return 32'h306A0000; "ni": return 32'h306B0000; "nu": return 32'h306C0000;
        "ne": return 32'h306D0000; "no": return 32'h306E0000;
        "ha": return 32'h306F0000; "hi": return 32'h30720000; "hu": return 32'h30750000;
        "fu": return 32'h30750000; "he": return 32'h30780000; "ho": return 32'h307B0000;
        "ba": return 32'h30700000; "bi": return 32'h30730000; "bu": return 32'h30760000;
        "be": return 32'h30790000; "bo": return 32'h307C0000;
        "pa": return 32'h30710000; "pi": return 32'h30740000; "pu": return 32'h30770000;
        "pe": return 32'h307A0000; "po": return 32'h307D0000;
        "ma": return 32'h307E0000; "mi": return 32'h307F0000; "mu": return 32'h30800000;
        "me": return 32'h30810000; "mo": return 32'h30820000;
        "ya": return 32'h30840000; "yu": return 32'h30860000; "yo": return 32'h30880000;
        "ra": return 32'h30890000; "ri": return 32'h308A0000; "ru": return 32'h308B0000;
        "re": return 32'h308C0000; "ro": return 32'h308D0000;
        "wa": return 32'h308F0000; "wo": return 32'h30920000;
        "ja": return 32'h30583083; "ju": return 32'h30583085; "jo": return 32'h30583087;
        "fa": return 32'h30753041; "fi": return 32'h30753043;
        "fe": return 32'h30753047; "fo": return 32'h30753049;
        "va": return 32'h30943041; "vi": return 32'h30943043; "vu": return 32'h30940000;
        "ve": return 32'h30943047; "vo": return 32'h30943049;
        "je": return 32'h30583047;
        "wi": return 32'h30463043; "we": return 32'h30463047; "ye": return 32'h30443047;
        "la": return 32'h30410000; "li": return 32'h30430000; "lu": return 32'h30450000;
        "le": return 32'h30470000; "lo": return 32'h30490000;
        "xa": return 32'h30410000; "xi": return 32'h30430000; "xu": return 32'h30450000;
        "xe": return 32'h30470000; "xo": return 32'h30490000;
        default: return 32'h0;
      endcase
      3: begin
        case (s[23:0])
          "shi": return 32'h30570000; "chi": return 32'h30610000;
          "tsu": return 32'h30640000;
          "she": return 32'h30573047; "che": return 32'h30613047;
          "tsa": return 32'h30643041; "tsi": return 32'h30643043;
          "tse": return 32'h30643047; "tso": return 32'h30643049;
          "lya", "xya": return 32'h30830000;
          "lyu", "xyu": return 32'h30850000;
          "lyo", "xyo": return 32'h30870000;
          "ltu", "xtu": return 32'h30630000;
          "lwa", "xwa": return 32'h308E0000;
          default: ;
        endcase
        // contracted y-row: consonant head then a small ya/yu/yo
        head = y_row_head(s[23:8]);
        if (head == 16'h0) return 32'h0;
        case (s[7:0])
          "a": return {head, 16'h3083};
          "u": return {head, 16'h3085};
          "o": return {head, 16'h3087};
          default: return 32'h0;
        endcase
      end
      4: return (s == "ltsu") ? 32'h30630000 : 32'h0;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic lower_consonant(input logic [15:0] c);
    return c >= CH_A && c <= CH_Z && c != "a" && c != "i" && c != "u" && c != "e" && c != "o";
  endfunction

  function automatic kana_t convert_window(input logic [15:0] c0, c1, c2, c3,
                                           input logic [2:0] avail);
    logic [15:0] w[4];
    int          av;
    logic [31:0] s, hit;
    logic        ascii;
    kana_t       r;
    w[0] = c0; w[1] = c1; w[2] = c2; w[3] = c3;
    av = (avail > 3'd4) ? 4 : int'(avail);
    r = '0;
    if (av == 0) return r;
    if (w[0] == CH_N && av >= 2 && (w[1] == CH_N || w[1] == CH_APOS))
      return '{3'd2, 2'd1, KANA_N, 16'h0};
    if (w[0] == CH_N && av >= 2 && lower_consonant(w[1]) && w[1] != CH_Y)
      return '{3'd1, 2'd1, KANA_N, 16'h0};
    if (av >= 2 && lower_consonant(w[0]) && w[0] != CH_N && w[1] == w[0])
      return '{3'd1, 2'd1, KANA_SOKUON, 16'h0};
    // longest prefix first; spellings are unique so the first hit wins
    for (int len = av; len >= 1; len--) begin
      s = '0;
      ascii = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (w[i][15:8] != 8'h0) ascii = 1'b0;
        s = {s[23:0], w[i][7:0]};
      end
      hit = ascii ? spelling_kana(len, s) : 32'h0;
      if (hit != 32'h0) begin
        r.consumed    = 3'(len);
        r.kana_first  = hit[31:16];
        r.kana_second = hit[15:0];
        r.kana_count  = (hit[15:0] != 16'h0) ? 2'd2 : 2'd1;
        return r;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Request driver and result checker
  // ------------------------------------------------------------------
  always @(negedge clk) busy_s <= busy;

  task automatic send_window(input logic [15:0] c0, c1, c2, c3, input logic [2:0] avail);
    int gap;
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_char0       <= c0;
    in_char1       <= c1;
    in_char2       <= c2;
    in_char3       <= c3;
    in_avail_count <= avail;
    do @(posedge clk); while (busy_s);
    pending_kana.push_back(convert_window(c0, c1, c2, c3, avail));
  endtask

  always @(negedge clk) begin
    kana_t exp_k;
    if (rst_n && out_valid) begin
      if (pending_kana.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: consumed %0d", out_consumed);
      end else begin
        exp_k = pending_kana.pop_front();
        if (out_consumed !== exp_k.consumed || out_kana_count !== exp_k.kana_count ||
            out_kana_first !== exp_k.kana_first || out_kana_second !== exp_k.kana_second) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%h/%h got %0d/%0d/%h/%h",
                     exp_k.consumed, exp_k.kana_count, exp_k.kana_first, exp_k.kana_second,
                     out_consumed, out_kana_count, out_kana_first, out_kana_second);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic string syllable(input int idx);
    case (idx)
      0: return "a";    1: return "ka";   2: return "shi";  3: return "tsu";
      4: return "kyo";  5: return "nn";   6: return "n'";   7: return "n";
      8: return "kk";   9: return "tt";  10: return "cha"; 11: return "ye";
      12: return "xwa"; 13: return "ltsu"; 14: return "nya"; 15: return "ji";
      16: return "fo";  17: return "vu";  18: return "she"; 19: return "ryu";
      20: return "o";   21: return "lyo"; 22: return "pp";  23: return "wo";
      24: return "zyu"; 25: return "tso"; 26: return "ltu"; 27: return "nk";
      28: return "hi";  29: return "tya"; 30: return "xtu"; 31: return "ss";
      default: return "e";
    endcase
  endfunction

  function automatic logic [15:0] noise_unit();
    string alpha;
    alpha = "aiueoknstyhmrwgzjdbpfvclxq'";
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16'h7F, 16'h20));
      default: return {8'h0, alpha[$urandom_range(alpha.len() - 1)]};
    endcase
  endfunction

  function automatic logic [2:0] pick_avail();
    return ($urandom_range(99) < 65) ? 3'd4 : 3'($urandom_range(7));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    send_window(16'h0, 16'h0, 16'h0, 16'h0, 3'd0);                // empty window
    send_window("l", "t", "s", "u", 3'd7);                        // count above window
    send_window("l", "t", "s", "u", 3'd4);
    send_window("l", "t", "s", "u", 3'd3);
    send_window("n", 16'h0, 16'h0, 16'h0, 3'd1);                  // lone n
    send_window("n", "n", 16'h0, 16'h0, 3'd1);
    send_window("n", "n", "a", 16'h0, 3'd3);
    send_window("n", CH_APOS, "a", 16'h0, 3'd3);
    send_window("n", "k", "a", 16'h0, 3'd3);
    send_window("n", "y", "a", 16'h0, 3'd3);
    send_window("n", "y", 16'h0, 16'h0, 3'd2);                    // partial syllable
    send_window("k", "k", "a", 16'h0, 3'd3);
    send_window("k", "y", "o", 16'h0, 3'd3);
    send_window("s", "h", "i", "x", 3'd4);
    send_window("K", "A", 16'h0, 16'h0, 3'd2);                    // uppercase
    send_window(16'h0161, "a", 16'h0, 16'h0, 3'd2);               // non-ASCII alias of a
    send_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    send_window("a", 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4);
    send_window("x", "w", "a", 16'h0, 3'd3);
    send_window("y", "e", 16'h0, 16'h0, 3'd2);
    send_window("t", "s", "o", 16'h0, 3'd3);
    send_window("v", "u", 16'h0, 16'h0, 3'd2);
  endtask

  // Windows cut out of strings of real syllables, mostly full
  task automatic test_random_words(input int count);
    string       text;
    logic [15:0] w[4];
    for (int n = 0; n < count; n++) begin
      text = "";
      while (text.len() < 4) text = {text, syllable($urandom_range(32))};
      for (int i = 0; i < 4; i++) begin
        w[i] = {8'h0, text[i]};
        if ($urandom_range(99) < 5) w[i] = noise_unit();
      end
      send_window(w[0], w[1], w[2], w[3], pick_avail());
    end
  endtask

  task automatic test_random_noise(input int count);
    for (int n = 0; n < count; n++)
      send_window(noise_unit(), noise_unit(), noise_unit(), noise_unit(),
                  3'($urandom_range(7)));
  endtask

  // Sender holds off until every outstanding request is answered
  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_kana.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_char0       = '0;
    in_char1       = '0;
    in_char2       = '0;
    in_char3       = '0;
    in_avail_count = '0;
    mismatches     = 0;
    cycles         = 0;
    idle_on        = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_words(600);
    test_drain_pause();
    idle_on = 1'b0;                   // back-to-back stretch
    test_random_words(300);
    idle_on = 1'b1;
    test_random_noise(400);
    test_random_words(300);

    start <= 1'b0;
    while (pending_kana.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
